[rtl/hmc_pkg.sv]
// ----------------------------------------------------------------------------
// hmc_pkg: shared types and constants for the chain statistics accumulator
// widths, defaults, and the record passed from the accumulate front to the
// back-end divider
// ----------------------------------------------------------------------------
package hmc_pkg;

  localparam int MAX_DRAWS_DEF  = 16384;
  localparam int MAX_CHAINS_DEF = 256;

  localparam logic [5:0]  DEPTH_LIMIT_RST = 6'd10;
  localparam logic [16:0] ACCEPT_ONE      = 17'd65536;
  localparam logic [22:0] GRAND_MAX       = 23'h7FFFFF;
  localparam logic [23:0] RATIO_MAX       = 24'hFFFFFF;
  localparam logic [1:0]  MIN_DRAWS       = 2'd2;

  typedef struct packed {
    logic        diverged;
    logic [5:0]  tree_depth;
    logic [16:0] accept_stat;
    logic [31:0] step_size;
    logic [23:0] energy;
    logic        chain_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  chain_number;
    logic [14:0] draw_total;
    logic [14:0] divergent_count;
    logic [14:0] depth_hit_count;
    logic [16:0] accept_mean;
    logic [31:0] final_step_size;
    logic [23:0] bfmi_ratio;
    logic        bfmi_valid;
    logic [22:0] all_divergent;
    logic [22:0] all_depth_hits;
    logic        overflowed;
  } out_item_t;

  // finished chain handed from the front end to the back end
  typedef struct packed {
    logic [7:0]  chain_number;
    logic [14:0] draw_total;
    logic [14:0] divergent_count;
    logic [14:0] depth_hit_count;
    logic [30:0] accept_sum;
    logic [31:0] final_step_size;
    logic [37:0] energy_sum;
    logic [60:0] energy_square_sum;
    logic [62:0] diff_square_sum;
    logic [22:0] all_divergent;
    logic [22:0] all_depth_hits;
    logic        overflowed;
  } chain_rec_t;

endpackage

[rtl/hmc_if.sv]
// ----------------------------------------------------------------------------
// hmc_if: valid/ready channel
// generic payload carrier with source and sink views
// ----------------------------------------------------------------------------
interface hmc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/hmc_front.sv]
// ----------------------------------------------------------------------------
// hmc_front: per-row accumulation
// updates tallies and energy sums for each item up to MAX_DRAWS draws, flags
// overflow past that, and emits a chain record on chain end
// ----------------------------------------------------------------------------
module hmc_front #(
  parameter int MAX_DRAWS  = hmc_pkg::MAX_DRAWS_DEF,
  parameter int MAX_CHAINS = hmc_pkg::MAX_CHAINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hmc_pkg::in_item_t  in_item,
  input  logic [5:0]         depth_limit,
  output logic               rec_valid,
  input  logic               rec_ready,
  output hmc_pkg::chain_rec_t rec
);
  localparam int CW = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;

  logic [23:0] prev_e_r;
  logic [14:0] draws_r;
  logic [37:0] esum_r;
  logic [60:0] esq_r;
  logic [62:0] dsq_r;
  logic [14:0] div_r, dep_r;
  logic [30:0] acc_r;
  logic [CW-1:0] chain_r;
  logic [22:0] gdiv_r, gdep_r;
  logic        ovf_r;

  logic        fire, room;
  logic [16:0] acc_c;
  logic signed [23:0] e_s;
  logic signed [24:0] d_s;
  logic [47:0] e2;
  logic [49:0] d2;
  logic [14:0] div_n, dep_n, draws_n;
  logic [30:0] acc_n;
  logic [37:0] esum_n;
  logic [60:0] esq_n;
  logic [62:0] dsq_n;
  logic        ovf_n;
  logic [23:0] gdiv_s, gdep_s;

  assign in_ready = !rec_valid || rec_ready;
  assign fire = in_valid && in_ready;
  assign room = 32'(draws_r) < MAX_DRAWS;

  always_comb begin
    acc_c = (in_item.accept_stat > hmc_pkg::ACCEPT_ONE) ? hmc_pkg::ACCEPT_ONE
                                                         : in_item.accept_stat;
    e_s = signed'(in_item.energy);
    d_s = 25'(e_s) - 25'(signed'(prev_e_r));
    e2 = 48'(e_s * e_s);
    d2 = 50'(d_s * d_s);
    div_n = div_r; dep_n = dep_r; acc_n = acc_r; esum_n = esum_r;
    esq_n = esq_r; dsq_n = dsq_r; draws_n = draws_r; ovf_n = ovf_r;
    if (room) begin
      div_n = div_r + 15'(in_item.diverged);
      dep_n = dep_r + 15'(in_item.tree_depth >= depth_limit);
      acc_n = acc_r + 31'(acc_c);
      esum_n = esum_r + 38'(e_s);
      esq_n = esq_r + 61'(e2);
      if (draws_r != '0) dsq_n = dsq_r + 63'(d2);
      draws_n = draws_r + 15'd1;
    end else begin
      ovf_n = 1'b1;
    end
    gdiv_s = 24'(gdiv_r) + 24'(div_n);
    gdep_s = 24'(gdep_r) + 24'(dep_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_e_r <= '0; draws_r <= '0; esum_r <= '0; esq_r <= '0; dsq_r <= '0;
      div_r <= '0; dep_r <= '0; acc_r <= '0; chain_r <= '0;
      gdiv_r <= '0; gdep_r <= '0; ovf_r <= 1'b0; rec_valid <= 1'b0;
    end else begin
      if (fire && in_item.chain_end) rec_valid <= 1'b1;
      else if (rec_ready) rec_valid <= 1'b0;
      if (fire) begin
        if (in_item.chain_end) begin
          rec.chain_number <= 8'(chain_r);
          rec.draw_total <= draws_n;
          rec.divergent_count <= div_n;
          rec.depth_hit_count <= dep_n;
          rec.accept_sum <= acc_n;
          rec.final_step_size <= in_item.step_size;
          rec.energy_sum <= esum_n;
          rec.energy_square_sum <= esq_n;
          rec.diff_square_sum <= dsq_n;
          rec.all_divergent <= gdiv_s[23] ? hmc_pkg::GRAND_MAX : gdiv_s[22:0];
          rec.all_depth_hits <= gdep_s[23] ? hmc_pkg::GRAND_MAX : gdep_s[22:0];
          rec.overflowed <= ovf_n;
          gdiv_r <= gdiv_s[23] ? hmc_pkg::GRAND_MAX : gdiv_s[22:0];
          gdep_r <= gdep_s[23] ? hmc_pkg::GRAND_MAX : gdep_s[22:0];
          chain_r <= (32'(chain_r) == MAX_CHAINS - 1) ? '0 : chain_r + CW'(1);
          prev_e_r <= '0; draws_r <= '0; esum_r <= '0; esq_r <= '0;
          dsq_r <= '0; div_r <= '0; dep_r <= '0; acc_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          if (room) prev_e_r <= in_item.energy;
          draws_r <= draws_n; esum_r <= esum_n; esq_r <= esq_n; dsq_r <= dsq_n;
          div_r <= div_n; dep_r <= dep_n; acc_r <= acc_n;
          ovf_r <= ovf_n;
        end
      end
    end
  end
endmodule

[rtl/hmc_queue.sv]
// ----------------------------------------------------------------------------
// hmc_queue: two-entry chain record queue
// decouples the accumulate front from the divide back end
// ----------------------------------------------------------------------------
module hmc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  hmc_pkg::chain_rec_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output hmc_pkg::chain_rec_t rd_data
);
  hmc_pkg::chain_rec_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

[rtl/hmc_back.sv]
// ----------------------------------------------------------------------------
// hmc_back: chain close-out
// forms the e-bfmi numerator and denominator with 32-bit partial products,
// then divides by restoring steps for the ratio, while a restoring divider started
// with the record forms the accept mean
module hmc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rec_valid,
  output logic                rec_ready,
  input  hmc_pkg::chain_rec_t rec,
  output logic                out_valid,
  input  logic                out_ready,
  output hmc_pkg::out_item_t  out_item
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUB, S_DIV, S_OUT} state_t;

  state_t state_r;
  hmc_pkg::chain_rec_t rec_r;
  logic [3:0]   ph_r;
  logic [127:0] a_r, b_r, c_r;
  logic [127:0] num_r, den_r;
  logic [4:0]   bit_r;
  logic [23:0]  q_r;
  logic [30:0]  arem_r;
  logic [16:0]  aq_r;
  logic         sat_r, valid_r;
  logic [37:0]  mag;
  logic [63:0]  pp;
  logic [31:0]  x, y;
  logic [127:0] t, tr;

  assign rec_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign mag = rec_r.energy_sum[37] ? 38'(-rec_r.energy_sum) : rec_r.energy_sum;

  // partial product selection: ph 0..1 n*esq, 2..5 mag*mag, 6..7 n*dsq
  always_comb begin
    x = '0; y = '0;
    unique case (ph_r)
      4'd0: begin x = 32'(rec_r.draw_total); y = rec_r.energy_square_sum[31:0]; end
      4'd1: begin x = 32'(rec_r.draw_total); y = 32'(rec_r.energy_square_sum[60:32]); end
      4'd2: begin x = mag[31:0]; y = mag[31:0]; end
      4'd3: begin x = mag[31:0]; y = 32'(mag[37:32]); end
      4'd4: begin x = 32'(mag[37:32]); y = mag[31:0]; end
      4'd5: begin x = 32'(mag[37:32]); y = 32'(mag[37:32]); end
      4'd6: begin x = 32'(rec_r.draw_total); y = rec_r.diff_square_sum[31:0]; end
      4'd7: begin x = 32'(rec_r.draw_total); y = 32'(rec_r.diff_square_sum[62:32]); end
      default: begin x = '0; y = '0; end
    endcase
    pp = x * y;
    t = den_r << bit_r;
    tr = num_r - t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (rec_valid) begin
          rec_r <= rec; ph_r <= '0;
          a_r <= '0; b_r <= '0; c_r <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          unique case (ph_r)
            4'd0: a_r <= a_r + 128'(pp);
            4'd1: a_r <= a_r + (128'(pp) << 32);
            4'd2: b_r <= b_r + 128'(pp);
            4'd3, 4'd4: b_r <= b_r + (128'(pp) << 32);
            4'd5: b_r <= b_r + (128'(pp) << 64);
            4'd6: c_r <= c_r + 128'(pp);
            4'd7: c_r <= c_r + (128'(pp) << 32);
            default: ;
          endcase
          if (ph_r == 4'd7) state_r <= S_SUB;
          ph_r <= ph_r + 4'd1;
        end
        S_SUB: begin
          den_r <= a_r - b_r;
          num_r <= c_r << 16;
          valid_r <= (rec_r.draw_total >= 15'(hmc_pkg::MIN_DRAWS)) && (a_r != b_r);
          sat_r <= (c_r << 16) >= ((a_r - b_r) << 24);
          bit_r <= 5'd23; q_r <= '0;
          ph_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (num_r >= t) begin
            num_r <= tr; q_r[bit_r] <= 1'b1;
          end
          bit_r <= bit_r - 5'd1;
          if (bit_r == 5'd0) state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // accept mean divider runs alongside: 31 restoring steps, done before S_OUT
  logic [4:0]  mb_r;
  logic [30:0] md_r;
  logic        mrun_r;
  logic [31:0] mt;
  always_comb mt = {arem_r, md_r[30]} ;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrun_r <= 1'b0;
    end else if (state_r == S_IDLE && rec_valid) begin
      mrun_r <= 1'b1; mb_r <= 5'd30; md_r <= rec.accept_sum;
      arem_r <= '0; aq_r <= '0;
    end else if (mrun_r) begin
      if (mt >= 32'(rec_r.draw_total)) begin
        arem_r <= 31'(mt - 32'(rec_r.draw_total));
        aq_r <= 17'({aq_r, 1'b1});
      end else begin
        arem_r <= mt[30:0];
        aq_r <= 17'({aq_r, 1'b0});
      end
      md_r <= {md_r[29:0], 1'b0};
      if (mb_r == 5'd0) mrun_r <= 1'b0;
      mb_r <= mb_r - 5'd1;
    end
  end

  always_comb begin
    out_item.chain_number    = rec_r.chain_number;
    out_item.draw_total      = rec_r.draw_total;
    out_item.divergent_count = rec_r.divergent_count;
    out_item.depth_hit_count = rec_r.depth_hit_count;
    out_item.accept_mean     = aq_r;
    out_item.final_step_size = rec_r.final_step_size;
    out_item.bfmi_ratio      = !valid_r ? '0 : (sat_r ? hmc_pkg::RATIO_MAX : q_r);
    out_item.bfmi_valid      = valid_r;
    out_item.all_divergent   = rec_r.all_divergent;
    out_item.all_depth_hits  = rec_r.all_depth_hits;
    out_item.overflowed      = rec_r.overflowed;
  end
endmodule

[rtl/hmc_chain_stats_accumulator.sv]
// ----------------------------------------------------------------------------
// hmc_chain_stats_accumulator: per-chain sampler diagnostics with e-bfmi
// accumulates one sampler row per cycle, except while a finished chain waits on a full
// queue, and closes each chain with counts, accept mean and the e-bfmi ratio
// ----------------------------------------------------------------------------
// Rows are accepted one per cycle. A row with chain_end hands the chain's
// totals to a two-entry queue; the back end then takes the record, forms
// eight 32x32 partial products, forms numerator and denominator, runs a
// 24-step restoring divide for the ratio while a bit-serial divider started
// with the record forms the accept mean, and hands the result over, taking
// no new record until that result is taken. Rows keep flowing while a chain
// closes; input stalls only while a finished chain waits for room in the
// full queue.
module hmc_chain_stats_accumulator #(
  parameter int MAX_DRAWS  = hmc_pkg::MAX_DRAWS_DEF,
  parameter int MAX_CHAINS = hmc_pkg::MAX_CHAINS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  hmc_if.sink        in_ch,
  hmc_if.source      out_ch
);
  logic [5:0] depth_limit_r;
  logic f_valid, f_ready, q_valid, q_ready;
  hmc_pkg::chain_rec_t f_rec, q_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) depth_limit_r <= hmc_pkg::DEPTH_LIMIT_RST;
    else if (cfg_we) depth_limit_r <= cfg_wdata;
  end

  hmc_front #(.MAX_DRAWS(MAX_DRAWS), .MAX_CHAINS(MAX_CHAINS)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(in_ch.payload), .depth_limit(depth_limit_r),
    .rec_valid(f_valid), .rec_ready(f_ready), .rec(f_rec));

  hmc_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_rec),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_rec));

  hmc_back u_back (
    .clk, .rst_n, .rec_valid(q_valid), .rec_ready(q_ready), .rec(q_rec),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload));

  a_ovf_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.payload.overflowed |->
      32'(out_ch.payload.draw_total) <= MAX_DRAWS)
    else $error("draw total beyond capacity");
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.payload.bfmi_valid |-> out_ch.payload.bfmi_ratio == '0)
    else $error("invalid ratio not zero");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped");
endmodule

[tb/hmc_chain_stats_accumulator_tb.sv]
// ----------------------------------------------------------------------------
// hmc_chain_stats_accumulator_tb: self-checking bench for the chain statistics
// accumulator. Sampler rows are streamed over the input channel. Each chain
// closed by chain_end is predicted in step: tallies, accept mean, grand
// totals and the exact e-bfmi quotient in 128-bit arithmetic. Every result is
// checked against the oldest prediction while both sides idle and stall.
// ----------------------------------------------------------------------------
module hmc_chain_stats_accumulator_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [5:0] cfg_wdata;

  hmc_if #(.payload_t(hmc_pkg::in_item_t)) in_ch ();
  hmc_if #(.payload_t(hmc_pkg::out_item_t)) out_ch ();

  hmc_chain_stats_accumulator dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // predicted chain summaries, oldest first
  hmc_pkg::out_item_t chain_summary_q[$];
  int mismatches;
  int unsigned cycles;
  int send_idle_pct;
  int recv_stall_pct;

  // mirror of the block's per-chain and running state
  logic [5:0] m_limit;
  logic [23:0] m_prev_energy;
  int unsigned m_draws;
  longint m_esum;
  logic [63:0] m_esq;
  logic [63:0] m_dsq;
  int unsigned m_div;
  int unsigned m_dep;
  int unsigned m_acc;
  logic [31:0] m_step;
  logic [7:0] m_chain;
  int unsigned m_gdiv;
  int unsigned m_gdep;
  bit m_ovf;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (chain_summary_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_ch.payload);
      end else begin
        if (out_ch.payload !== chain_summary_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch\n  exp %p\n  act %p", chain_summary_q[0], out_ch.payload);
        end
        void'(chain_summary_q.pop_front());
      end
    end
  end

  function automatic int unsigned sat23(int unsigned a, int unsigned b);
    return (a + b > 32'h7FFFFF) ? 32'h7FFFFF : a + b;
  endfunction

  task automatic clear_chain_state();
    m_prev_energy = '0;
    m_draws = 0;
    m_esum = 0;
    m_esq = '0;
    m_dsq = '0;
    m_div = 0;
    m_dep = 0;
    m_acc = 0;
    m_step = '0;
    m_ovf = 1'b0;
  endtask

  // fold one accepted row into the mirror; a chain end yields a summary
  task automatic absorb_row(input hmc_pkg::in_item_t r);
    int unsigned acc;
    longint e;
    longint d;
    logic [127:0] mag;
    logic [127:0] den;
    logic [127:0] num;
    hmc_pkg::out_item_t s;
    acc = (r.accept_stat > hmc_pkg::ACCEPT_ONE) ? hmc_pkg::ACCEPT_ONE : r.accept_stat;
    e = longint'(signed'(r.energy));
    if (m_draws < hmc_pkg::MAX_DRAWS_DEF) begin
      if (r.diverged) m_div++;
      if (r.tree_depth >= m_limit) m_dep++;
      m_acc += acc;
      m_esum += e;
      m_esq += 64'(e * e);
      if (m_draws > 0) begin
        d = e - longint'(signed'(m_prev_energy));
        m_dsq += 64'(d * d);
      end
      m_prev_energy = r.energy;
      m_draws++;
    end else begin
      m_ovf = 1'b1;
    end
    m_step = r.step_size;
    if (!r.chain_end) return;
    s = '0;
    s.chain_number = m_chain;
    s.draw_total = 15'(m_draws);
    s.divergent_count = 15'(m_div);
    s.depth_hit_count = 15'(m_dep);
    s.accept_mean = (m_draws > 0) ? 17'(m_acc / m_draws) : '0;
    s.final_step_size = m_step;
    if (m_draws >= 2) begin
      mag = (m_esum < 0) ? 128'(-m_esum) : 128'(m_esum);
      den = 128'(m_draws) * 128'(m_esq) - mag * mag;
      if (den != 0) begin
        num = (128'(m_draws) * 128'(m_dsq)) << 16;
        s.bfmi_valid = 1'b1;
        s.bfmi_ratio = (num >= (den << 24)) ? hmc_pkg::RATIO_MAX : 24'(num / den);
      end
    end
    m_gdiv = sat23(m_gdiv, m_div);
    m_gdep = sat23(m_gdep, m_dep);
    s.all_divergent = 23'(m_gdiv);
    s.all_depth_hits = 23'(m_gdep);
    s.overflowed = m_ovf;
    chain_summary_q.insert(chain_summary_q.size(), s);
    m_chain++;
    clear_chain_state();
  endtask

  task automatic send_row(input hmc_pkg::in_item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.payload = r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_row(r);
    @(negedge clk);
  endtask

  task automatic send_fields(input bit dv, input int dep, input int acc, input logic [31:0] st,
                             input int en, input bit last);
    hmc_pkg::in_item_t r;
    r.diverged = dv;
    r.tree_depth = 6'(dep);
    r.accept_stat = 17'(acc);
    r.step_size = st;
    r.energy = 24'(en);
    r.chain_end = last;
    send_row(r);
  endtask

  // let the block drain, then change the depth limit
  task automatic set_depth_limit(input logic [5:0] v);
    in_ch.valid = 1'b0;
    wait (chain_summary_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    m_limit = v;
  endtask

  task automatic test_field_extremes();
    send_fields(1, 63, 131071, 32'hFFFFFFFF, 8388607, 1);
    send_fields(0, 0, 65536, 32'h0, -8388608, 0);
    send_fields(1, 10, 65537, 32'h5555AAAA, -8388608, 0);
    send_fields(0, 9, 0, 32'hAAAA5555, -8388608, 1);
    send_fields(1, 63, 65535, 32'h0, -8388608, 0);
    send_fields(0, 0, 1, 32'hFFFFFFFF, 8388607, 0);
    send_fields(1, 31, 100000, 32'h12345678, -8388608, 0);
    send_fields(0, 32, 32768, 32'h87654321, 8388607, 1);
    in_ch.valid = 1'b0;
  endtask

  task automatic test_depth_limits();
    logic [5:0] lims[4];
    lims = '{6'd0, 6'd1, 6'd63, 6'd10};
    foreach (lims[i]) begin
      set_depth_limit(lims[i]);
      send_fields(0, 0, 10, 32'd1, 256, 0);
      send_fields(1, 1, 20, 32'd2, 512, 0);
      send_fields(0, 62, 30, 32'd3, -256, 0);
      send_fields(1, 63, 40, 32'd4, 0, 1);
      in_ch.valid = 1'b0;
    end
  endtask

  task automatic test_random_chains(input int rows, input int idle, input int stall);
    int sent;
    int len;
    int shape;
    int base;
    int en;
    int acc;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < rows) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 8);
      shape = $urandom_range(3);
      base = $urandom_range(16777215) - 8388608;
      for (int i = 0; i < len; i++) begin
        case (shape)
          0: en = $urandom_range(16777215) - 8388608;
          1: en = base + $urandom_range(1000) - 500;
          2: en = base;
          default: en = (i % 2) ? 8388607 : -8388608;
        endcase
        if (en > 8388607) en = 8388607;
        if (en < -8388608) en = -8388608;
        acc = ($urandom_range(7) == 0) ? $urandom_range(131071) : $urandom_range(65536);
        send_fields($urandom_range(1), $urandom_range(63), acc, $urandom(), en, i == len - 1);
      end
      sent += len;
    end
    in_ch.valid = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    m_limit = hmc_pkg::DEPTH_LIMIT_RST;
    m_chain = '0;
    m_gdiv = 0;
    m_gdep = 0;
    clear_chain_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_depth_limits();
    test_random_chains(300, 0, 0);
    set_depth_limit(6'($urandom_range(63)));
    test_random_chains(250, 70, 0);
    set_depth_limit(6'd1);
    test_random_chains(250, 0, 70);
    set_depth_limit(6'd63);
    test_random_chains(250, 16, 16);

    wait (chain_summary_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && chain_summary_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[hmc_chain_stats_accumulator.f]
rtl/hmc_pkg.sv
rtl/hmc_if.sv
rtl/hmc_front.sv
rtl/hmc_queue.sv
rtl/hmc_back.sv
rtl/hmc_chain_stats_accumulator.sv
tb/hmc_chain_stats_accumulator_tb.sv
